[rtl/core/sha256_pkg.sv]
// Shared constants, types and SHA-256 helper functions for the stream hasher.
package sha256_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned WordCount = 8;
   localparam int unsigned RoundCount = 64;
   localparam logic [7:0] PadMark = 8'h80;
   localparam logic [5:0] LengthStart = 6'd56;
   localparam logic [5:0] LastFill = 6'd63;
   localparam logic [5:0] LastRound = 6'd63;
   localparam logic [2:0] LastWord = 3'd7;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic reinit;
   } round_ctrl_type;

   typedef struct packed {
      logic shift_byte;
      logic step;
   } sched_ctrl_type;

   localparam word_type RoundK [RoundCount] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitialH [WordCount] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sum_a(input word_type x);
      sum_a = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type sum_e(input word_type x);
      sum_e = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

[rtl/core/sha256_if.sv]
// Valid/ready channel interfaces for the hasher's byte input and digest output.
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source (output valid, output digest_word, output word_number,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_number,
                 input last_word, output ready);
endinterface

[rtl/core/sha256_sched.sv]
// Block gather register that doubles as the 16-word message schedule window.
module sha256_sched import sha256_pkg::*; (
   input  logic           clock,
   input  sched_ctrl_type ctrl,
   input  logic [7:0]     byte_in,
   output word_type       w_out
);

   // Word t of the window sits at bits [511-32t -: 32]; bytes enter at the bottom.
   logic [511:0] window_ff;
   logic [511:0] window_in;
   word_type     w1;
   word_type     w9;
   word_type     w14;
   word_type     w16;

   assign w_out = window_ff[511:480];
   assign w1    = window_ff[479:448];
   assign w9    = window_ff[223:192];
   assign w14   = window_ff[63:32];
   assign w16   = w_out + small_sigma0(w1) + w9 + small_sigma1(w14);

   always_comb begin
      window_in = window_ff;
      if (ctrl.shift_byte) begin
         window_in = {window_ff[503:0], byte_in};
      end else if (ctrl.step) begin
         window_in = {window_ff[479:0], w16};
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

[rtl/core/sha256_round.sv]
// Compression round unit: working variables, one round per cycle, and chaining words.
module sha256_round import sha256_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  round_ctrl_type ctrl,
   input  logic [5:0]     round_idx,
   input  word_type       w_in,
   input  logic [2:0]     word_sel,
   output word_type       digest_word
);

   word_type h_ff [WordCount];
   word_type h_in [WordCount];
   word_type v_ff [WordCount];
   word_type v_in [WordCount];
   word_type t1;
   word_type t2;
   word_type ch;
   word_type maj;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + sum_e(v_ff[4]) + ch + RoundK[round_idx] + w_in;
   assign t2  = sum_a(v_ff[0]) + maj;

   assign digest_word = h_ff[word_sel];

   always_comb begin
      for (int i = 0; i < WordCount; i++) begin
         h_in[i] = h_ff[i];
         v_in[i] = v_ff[i];
      end
      if (ctrl.reinit) begin
         for (int i = 0; i < WordCount; i++) begin
            h_in[i] = InitialH[i];
         end
      end else if (ctrl.fold) begin
         for (int i = 0; i < WordCount; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
      if (ctrl.load) begin
         for (int i = 0; i < WordCount; i++) begin
            v_in[i] = h_ff[i];
         end
      end else if (ctrl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WordCount; i++) begin
            h_ff[i] <= InitialH[i];
         end
      end else begin
         for (int i = 0; i < WordCount; i++) begin
            h_ff[i] <= h_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WordCount; i++) begin
         v_ff[i] <= v_in[i];
      end
   end

endmodule

[rtl/core/sha256_stream_hasher.sv]
// Top level of the streaming SHA-256 hasher: byte intake, padding sequencer, digest output.
//
//   channel  direction  carries                                     handshake
//   req      in         data_byte, byte_present, end_of_message     valid/ready
//   rsp      out        digest_word, word_number, last_word         valid/ready
//
// The hasher takes bytes while it is idle. The byte that fills a 64-byte block starts a
// compression in the shared round unit: the 64 rounds, then a fold into the chaining
// words, during which req.ready is low. At end of message the sequencer feeds the pad
// bytes through the same path, one per cycle while no compression runs (up to 64, or up
// to 72 with an extra compression), then the final compression, then eight digest items,
// one per cycle while rsp.ready is high; a stalled item holds. Synchronous reset loads the
// initial chaining words and clears the counters; no clearing pass is needed.
module sha256_stream_hasher import sha256_pkg::*; (
   input logic        clock,
   input logic        reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_FOLD  = 3'd2;
   localparam logic [2:0] S_PAD   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  word_ff, word_in;
   logic        pad_ff, pad_in;
   logic        mark_ff, mark_in;
   logic        len_ff, len_in;
   logic        final_ff, final_in;

   logic           req_fire;
   logic           rsp_fire;
   logic           inject;
   logic           block_full;
   logic           is_len;
   logic [7:0]     inject_byte;
   logic [7:0]     pad_byte;
   word_type       w_t;
   round_ctrl_type round_ctrl;
   sched_ctrl_type sched_ctrl;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;

   // Once the mark is in, the length bytes start when the fill reaches 56.
   assign is_len   = mark_ff && (len_ff || (fill_ff == LengthStart));
   assign pad_byte = !mark_ff ? PadMark : (is_len ? count_ff[60:53] : 8'h00);

   always_comb begin
      inject      = 1'b0;
      inject_byte = pad_byte;
      if (state_ff == S_IDLE) begin
         inject      = req_fire && req.byte_present;
         inject_byte = req.data_byte;
      end else if (state_ff == S_PAD) begin
         inject = 1'b1;
      end
   end

   assign block_full = inject && (fill_ff == LastFill);

   always_comb begin
      state_in = state_ff;
      fill_in  = inject ? fill_ff + 6'd1 : fill_ff;
      count_in = count_ff;
      round_in = round_ff;
      word_in  = word_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      len_in   = len_ff;
      final_in = final_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (inject) begin
               count_in = count_ff + 61'd1;
            end
            if (req_fire) begin
               if (block_full) begin
                  state_in = S_ROUND;
                  pad_in   = req.end_of_message;
               end else if (req.end_of_message) begin
                  state_in = S_PAD;
                  pad_in   = 1'b1;
               end
            end
         end
         S_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == LastRound) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            if (final_ff) begin
               state_in = S_OUT;
            end else if (pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            mark_in = 1'b1;
            if (is_len) begin
               len_in   = 1'b1;
               // The length goes out most significant byte first.
               count_in = {count_ff[52:0], 8'h00};
            end
            if (block_full) begin
               state_in = S_ROUND;
               final_in = is_len;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LastWord) begin
                  state_in = S_IDLE;
                  count_in = '0;
                  pad_in   = 1'b0;
                  mark_in  = 1'b0;
                  len_in   = 1'b0;
                  final_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         round_ff <= '0;
         word_ff  <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         len_ff   <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         len_ff   <= len_in;
         final_ff <= final_in;
      end
   end

   assign sched_ctrl.shift_byte = inject;
   assign sched_ctrl.step       = (state_ff == S_ROUND);

   assign round_ctrl.load   = block_full;
   assign round_ctrl.step   = (state_ff == S_ROUND);
   assign round_ctrl.fold   = (state_ff == S_FOLD);
   assign round_ctrl.reinit = rsp_fire && (word_ff == LastWord);

   sha256_sched u_sched (
      .clock   (clock),
      .ctrl    (sched_ctrl),
      .byte_in (inject_byte),
      .w_out   (w_t)
   );

   sha256_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (round_ctrl),
      .round_idx   (round_ff),
      .w_in        (w_t),
      .word_sel    (word_ff),
      .digest_word (rsp.digest_word)
   );

   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.word_number = word_ff;
   assign rsp.last_word   = (word_ff == LastWord);

   a_no_intake_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input accepted while digest items are pending");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_word |=> req.ready && !rsp.valid)
      else $error("hasher did not return to intake after the last digest item");

   a_word_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.last_word |=>
         rsp.valid && (rsp.word_number == $past(rsp.word_number) + 3'd1))
      else $error("digest items out of sequence");

   a_rounds_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      round_ctrl.load |-> round_ff == '0)
      else $error("compression started with a nonzero round count");

endmodule

[tb/sha256_digest_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts SHA-256 digests from accepted input items and compares the output.
module sha256_digest_checker (
   input  logic  clock,
   input  logic  reset,
   sha256_req_if req,
   sha256_rsp_if rsp,
   output int    fail_count,
   output int    pending_words
);

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } digest_item_type;

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] StartWords [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PadByte = 8'h80;
   localparam int unsigned LengthOffset = 56;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned MaxReports = 10;

   logic [31:0]     chain_h [8];
   logic [7:0]      msg_block [64];
   int unsigned     block_bytes;
   logic [60:0]     msg_bytes;
   digest_item_type digest_queue [$];
   digest_item_type want;

   function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      logic [63:0] doubled;
      doubled = {x, x} >> n;
      return doubled[31:0];
   endfunction

   function void init_state();
      for (int i = 0; i < 8; i++) chain_h[i] = StartWords[i];
      block_bytes = 0;
      msg_bytes = '0;
   endfunction

   function void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      {a, b, c, d} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3]};
      {e, f, g, h} = {chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
              + RoundConst[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g;
         g = f;
         f = e;
         e = d + t1;
         d = c;
         c = b;
         b = a;
         a = t1 + t2;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
      chain_h[5] += f;
      chain_h[6] += g;
      chain_h[7] += h;
   endfunction

   // A byte is absorbed before the end flag is handled, so both may come in one item.
   function void absorb_item(input logic [7:0] data, input logic present, input logic done);
      logic [63:0] bit_len;
      digest_item_type next_item;
      if (present) begin
         msg_block[block_bytes] = data;
         block_bytes++;
         msg_bytes++;
         if (block_bytes == BlockBytes) begin
            compress_block();
            block_bytes = 0;
         end
      end
      if (done) begin
         bit_len = {msg_bytes, 3'b000};
         msg_block[block_bytes] = PadByte;
         block_bytes++;
         // The length field no longer fits, so the padding spills into one more block.
         if (block_bytes > LengthOffset) begin
            for (int i = block_bytes; i < BlockBytes; i++) msg_block[i] = 8'h00;
            compress_block();
            block_bytes = 0;
         end
         for (int i = block_bytes; i < LengthOffset; i++) msg_block[i] = 8'h00;
         for (int i = 0; i < 8; i++) msg_block[LengthOffset + i] = bit_len[63 - 8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            next_item = '{digest_word: chain_h[i], word_number: 3'(i),
                          last_word: (i == 7)};
            digest_queue.insert(digest_queue.size(), next_item);
         end
         init_state();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         init_state();
         digest_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (digest_queue.size() == 0) begin
               if (fail_count < MaxReports)
                  $display("%t: digest word %0d = %h arrived with nothing expected",
                           $realtime, rsp.word_number, rsp.digest_word);
               fail_count++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp.digest_word !== want.digest_word || rsp.word_number !== want.word_number
                   || rsp.last_word !== want.last_word) begin
                  if (fail_count < MaxReports)
                     $display("%t: expected word %0d %h last %b, got word %0d %h last %b",
                              $realtime, want.word_number, want.digest_word, want.last_word,
                              rsp.word_number, rsp.digest_word, rsp.last_word);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            absorb_item(req.data_byte, req.byte_present, req.end_of_message);
      end
      pending_words = digest_queue.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Top-level testbench for the stream hasher: clock, reset, message stimulus and verdict.
module tb;

   logic clock;
   logic reset;
   int   check_fails;
   int   words_pending;
   int   items_sent;
   int   hold_seq;
   bit   send_idle;
   bit   sink_idle;

   sha256_req_if req_ch ();
   sha256_rsp_if rsp_ch ();

   sha256_stream_hasher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   sha256_digest_checker digest_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .fail_count    (check_fails),
      .pending_words (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

   // Offers one item and returns at the edge where it is accepted.
   task automatic send_item(input logic [7:0] data, input logic present, input logic done);
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.byte_present <= present;
      req_ch.end_of_message <= done;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // A message of random bytes; the end flag rides on the last byte or on an item of its own.
   task automatic send_message(input int len, input bit noisy);
      bit end_on_byte;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic drain_digests();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (words_pending == 0);
      @(posedge clock);
   endtask

   // Output side: random stall bursts, plus one long hold-off when asked for.
   initial begin
      int hold_seen;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      int boundary_lens [4];
      int msg_num;
      int len;
      boundary_lens = '{56, 64, 55, 119};
      msg_num = 0;
      items_sent = 0;
      hold_seq = 0;
      send_idle = 1'b1;
      sink_idle = 1'b1;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.byte_present <= 1'b0;
      req_ch.end_of_message <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty messages, back to back.
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      // "abc" with the end flag on the last byte.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Extreme byte values with two ignored items in between.
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      // End flag on an item whose byte is not part of the message, then on one whose byte is.
      send_item(8'hA5, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);

      // Hold the output long enough that the block backs up into its input.
      hold_seq++;
      for (int i = 0; i < 3; i++) send_message(5, 1'b1);
      drain_digests();

      while (items_sent < 250) begin
         send_idle = (items_sent < 210) && ($urandom_range(0, 3) != 0);
         sink_idle = (items_sent < 210) && ($urandom_range(0, 3) != 0);
         if (msg_num % 3 == 1)
            len = boundary_lens[(msg_num / 3) % 4];
         else
            len = $urandom_range(0, 20);
         send_message(len, 1'b1);
         msg_num++;
      end
      drain_digests();
      repeat (300) @(posedge clock);

      if (check_fails == 0 && words_pending == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/sha256_pkg.sv
rtl/core/sha256_if.sv
rtl/core/sha256_sched.sv
rtl/core/sha256_round.sv
rtl/core/sha256_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/tb.sv
